// ----- rtl/icmp_pkg.sv -----
// shared types, constants and helpers of the icmp echo responder
`default_nettype none
package icmp_pkg;

    localparam int HdrLen   = 38;
    localparam int IdxWidth = 6;
    localparam int SumWidth = 20;
    localparam int AddrWidth = 4;
    localparam int DataWidth = 64;

    localparam logic [IdxWidth-1:0] IdxEthTypeHi = 6'd12;
    localparam logic [IdxWidth-1:0] IdxEthTypeLo = 6'd13;
    localparam logic [IdxWidth-1:0] IdxIpHdr     = 6'd14;
    localparam logic [IdxWidth-1:0] IdxProto     = 6'd23;
    localparam logic [IdxWidth-1:0] IdxIpCkHi    = 6'd24;
    localparam logic [IdxWidth-1:0] IdxIpCkLo    = 6'd25;
    localparam logic [IdxWidth-1:0] IdxSrcIp     = 6'd26;
    localparam logic [IdxWidth-1:0] IdxDstIp     = 6'd30;
    localparam logic [IdxWidth-1:0] IdxIpEnd     = 6'd34;
    localparam logic [IdxWidth-1:0] IdxIcmpType  = 6'd34;
    localparam logic [IdxWidth-1:0] IdxIcmpCkHi  = 6'd36;
    localparam logic [IdxWidth-1:0] IdxIcmpCkLo  = 6'd37;
    localparam logic [IdxWidth-1:0] IdxLast      = 6'(HdrLen - 1);

    localparam logic [7:0]  EthTypeIpv4Hi = 8'h08;
    localparam logic [7:0]  EthTypeIpv4Lo = 8'h00;
    localparam logic [7:0]  ProtoIcmp     = 8'h01;
    localparam logic [7:0]  IcmpEchoReq   = 8'h08;
    localparam logic [7:0]  IcmpEchoReply = 8'h00;
    localparam logic [15:0] IcmpCkAdjust  = 16'hf7ff;

    localparam logic RegLocalMac = 1'b0;
    localparam logic RegLocalIp  = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic                match;
        logic [SumWidth-1:0] ip_sum;
        logic [15:0]         icmp_ck;
    } hdr_info_t;

    function automatic logic [15:0] fold16(input logic [SumWidth-1:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, s[15:0]} + 17'(s[SumWidth-1:16]);
        s2 = {1'b0, s1[15:0]} + 17'(s1[16]);
        return s2[15:0] & 16'hffff;
    endfunction

    // source index in the stored header for reply byte i
    function automatic logic [IdxWidth-1:0] reply_src(input logic [IdxWidth-1:0] i);
        logic [IdxWidth-1:0] r;
        r = i;
        if (i < 6'd6)
        begin
            r = i + 6'd6;
        end
        else if (i < IdxEthTypeHi)
        begin
            r = i - 6'd6;
        end
        else if (i >= IdxSrcIp && i < IdxDstIp)
        begin
            r = i + 6'd4;
        end
        else if (i >= IdxDstIp && i < IdxIpEnd)
        begin
            r = i - 6'd4;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/icmp_apb_regs.sv -----
// apb register block holding the local mac and ip addresses
`default_nettype none
module icmp_apb_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [icmp_pkg::AddrWidth-1:0]   paddr,
    input  wire logic [icmp_pkg::DataWidth-1:0]   pwdata,
    output logic      [icmp_pkg::DataWidth-1:0]   prdata,
    output logic                                  pready,
    output logic      [47:0]                      local_mac,
    output logic      [31:0]                      local_ip
);

    logic [47:0] mac_reg;
    logic [47:0] mac_next;
    logic [31:0] ip_reg;
    logic [31:0] ip_next;
    logic        wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        mac_next = mac_reg;
        ip_next  = ip_reg;
        if (wr_en)
        begin
            case (paddr[3])
                icmp_pkg::RegLocalMac: mac_next = pwdata[47:0];
                icmp_pkg::RegLocalIp:  ip_next  = pwdata[31:0];
                default:               mac_next = mac_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3])
            icmp_pkg::RegLocalMac: prdata = {16'h0, mac_reg};
            icmp_pkg::RegLocalIp:  prdata = {32'h0, ip_reg};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_reg <= '0;
            ip_reg  <= '0;
        end
        else
        begin
            mac_reg <= mac_next;
            ip_reg  <= ip_next;
        end
    end

    assign local_mac = mac_reg;
    assign local_ip  = ip_reg;

endmodule
`default_nettype wire

// ----- rtl/icmp_hdr_ram.sv -----
// header byte store with one write port and a registered read port
`default_nettype none
module icmp_hdr_ram (
    input  wire logic                            clk,
    input  wire logic                            wr_en,
    input  wire logic [icmp_pkg::IdxWidth-1:0]   wr_addr,
    input  wire logic [7:0]                      wr_data,
    input  wire logic                            rd_en,
    input  wire logic [icmp_pkg::IdxWidth-1:0]   rd_addr,
    output logic      [7:0]                      rd_data
);

    logic [7:0] mem [icmp_pkg::HdrLen];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- rtl/icmp_hdr_check.sv -----
// byte-serial header match and checksum accumulation while collecting
`default_nettype none
module icmp_hdr_check (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic [icmp_pkg::IdxWidth-1:0]   idx,
    input  wire logic [7:0]                      data,
    input  wire logic [47:0]                     local_mac,
    input  wire logic [31:0]                     local_ip,
    output icmp_pkg::hdr_info_t                  info
);

    logic                          match_reg;
    logic                          match_next;
    logic [icmp_pkg::SumWidth-1:0] sum_reg;
    logic [icmp_pkg::SumWidth-1:0] sum_next;
    logic [15:0]                   ck_reg;
    logic [15:0]                   ck_next;
    logic [7:0]                    mac_b [6];
    logic [7:0]                    ip_b [4];
    logic [1:0]                    ip_sel;
    logic                          ok;
    logic                          in_sum;
    logic [icmp_pkg::SumWidth-1:0] term;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            mac_b[k] = local_mac[8*(5-k) +: 8];
        end
        for (int k = 0; k < 4; k++)
        begin
            ip_b[k] = local_ip[8*(3-k) +: 8];
        end
    end

    assign ip_sel = 2'(idx - icmp_pkg::IdxDstIp);

    always_comb
    begin
        ok = 1'b1;
        if (idx < 6'd6)
        begin
            ok = (data == mac_b[idx[2:0]]);
        end
        else if (idx == icmp_pkg::IdxEthTypeHi)
        begin
            ok = (data == icmp_pkg::EthTypeIpv4Hi);
        end
        else if (idx == icmp_pkg::IdxEthTypeLo)
        begin
            ok = (data == icmp_pkg::EthTypeIpv4Lo);
        end
        else if (idx == icmp_pkg::IdxProto)
        begin
            ok = (data == icmp_pkg::ProtoIcmp);
        end
        else if (idx >= icmp_pkg::IdxDstIp && idx < icmp_pkg::IdxIpEnd)
        begin
            ok = (data == ip_b[ip_sel]);
        end
        else if (idx == icmp_pkg::IdxIcmpType)
        begin
            ok = (data == icmp_pkg::IcmpEchoReq);
        end
    end

    // header checksum field counts as zero
    assign in_sum = (idx >= icmp_pkg::IdxIpHdr) && (idx < icmp_pkg::IdxIpEnd)
                    && (idx != icmp_pkg::IdxIpCkHi) && (idx != icmp_pkg::IdxIpCkLo);
    assign term   = idx[0] ? {12'h0, data} : {4'h0, data, 8'h0};

    always_comb
    begin
        match_next = match_reg;
        sum_next   = sum_reg;
        ck_next    = ck_reg;
        if (en)
        begin
            match_next = ((idx == '0) ? 1'b1 : match_reg) & ok;
            if (idx == '0)
            begin
                sum_next = '0;
            end
            else if (in_sum)
            begin
                sum_next = sum_reg + term;
            end
            if (idx == icmp_pkg::IdxIcmpCkHi)
            begin
                ck_next[15:8] = data;
            end
            if (idx == icmp_pkg::IdxIcmpCkLo)
            begin
                ck_next[7:0] = data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        ck_reg  <= ck_next;
    end

    assign info.match   = match_reg;
    assign info.ip_sum  = sum_reg;
    assign info.icmp_ck = ck_reg;

endmodule
`default_nettype wire

// ----- rtl/icmp_echo_responder_core.sv -----
// top level of the icmp echo responder
// Frames enter one byte per transfer. The first 38 bytes (ethernet, ipv4 with
// ihl 5, and the first icmp word) are taken at one byte per cycle into a small
// header memory while the address match and the ipv4 header sum are built up
// a byte at a time. After the 38th byte a qualifying echo request is answered:
// each of the 38 rewritten header bytes is read from the memory and then loaded
// into the output register while input stalls, and every later byte passes
// through at one per cycle while the output slot is free. Other frames and
// short frames are dropped without output. local_mac sits at address 0 and
// local_ip at address 8 of the 64-bit apb port.
`default_nettype none
module icmp_echo_responder_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire icmp_pkg::in_item_t               in_item,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output icmp_pkg::out_item_t                   out_item,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [icmp_pkg::AddrWidth-1:0]   paddr,
    input  wire logic [icmp_pkg::DataWidth-1:0]   pwdata,
    output logic      [icmp_pkg::DataWidth-1:0]   prdata,
    output logic                                  pready
);

    typedef enum logic [3:0] {
        StCollect = 4'b0001,
        StEmit    = 4'b0010,
        StPass    = 4'b0100,
        StDrop    = 4'b1000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [icmp_pkg::IdxWidth-1:0]   cnt_reg;
    logic [icmp_pkg::IdxWidth-1:0]   cnt_next;
    logic [icmp_pkg::IdxWidth-1:0]   emit_reg;
    logic [icmp_pkg::IdxWidth-1:0]   emit_next;
    logic                            phase_reg;
    logic                            phase_next;
    logic                            hdr_last_reg;
    logic                            hdr_last_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    icmp_pkg::out_item_t             out_item_reg;
    icmp_pkg::out_item_t             out_item_next;

    logic [47:0]                     local_mac;
    logic [31:0]                     local_ip;
    icmp_pkg::hdr_info_t             info;
    logic                            in_xfer;
    logic                            collect_wr;
    logic                            slot_free;
    logic                            rd_en;
    logic [7:0]                      rd_data;
    logic [15:0]                     ip_ck;
    logic [15:0]                     icmp_ck;
    logic [7:0]                      emit_byte;

    icmp_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .local_mac (local_mac),
        .local_ip  (local_ip)
    );

    assign slot_free  = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == StCollect) || (state_reg == StDrop)
                        || ((state_reg == StPass) && slot_free);
    assign in_xfer    = in_valid && in_ready;
    assign collect_wr = in_xfer && (state_reg == StCollect);
    assign rd_en      = (state_reg == StEmit) && !phase_reg;

    icmp_hdr_ram u_ram (
        .clk     (clk),
        .wr_en   (collect_wr),
        .wr_addr (cnt_reg),
        .wr_data (in_item.in_byte),
        .rd_en   (rd_en),
        .rd_addr (icmp_pkg::reply_src(emit_reg)),
        .rd_data (rd_data)
    );

    icmp_hdr_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (collect_wr),
        .idx       (cnt_reg),
        .data      (in_item.in_byte),
        .local_mac (local_mac),
        .local_ip  (local_ip),
        .info      (info)
    );

    assign ip_ck   = ~icmp_pkg::fold16(info.ip_sum);
    assign icmp_ck = ~icmp_pkg::fold16(icmp_pkg::SumWidth'({1'b0, ~info.icmp_ck}
                     + {1'b0, icmp_pkg::IcmpCkAdjust}));

    always_comb
    begin
        case (emit_reg)
            icmp_pkg::IdxIpCkHi:   emit_byte = ip_ck[15:8];
            icmp_pkg::IdxIpCkLo:   emit_byte = ip_ck[7:0];
            icmp_pkg::IdxIcmpType: emit_byte = icmp_pkg::IcmpEchoReply;
            icmp_pkg::IdxIcmpCkHi: emit_byte = icmp_ck[15:8];
            icmp_pkg::IdxIcmpCkLo: emit_byte = icmp_ck[7:0];
            default:               emit_byte = rd_data;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        emit_next      = emit_reg;
        phase_next     = phase_reg;
        hdr_last_next  = hdr_last_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            StCollect:
            begin
                if (in_xfer)
                begin
                    if (cnt_reg == icmp_pkg::IdxLast)
                    begin
                        cnt_next = '0;
                        if (info.match)
                        begin
                            state_next    = StEmit;
                            emit_next     = '0;
                            phase_next    = 1'b0;
                            hdr_last_next = in_item.in_last;
                        end
                        else if (!in_item.in_last)
                        begin
                            state_next = StDrop;
                        end
                    end
                    else if (in_item.in_last)
                    begin
                        cnt_next = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            StEmit:
            begin
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_item_next.out_byte = emit_byte;
                    out_item_next.out_last = (emit_reg == icmp_pkg::IdxLast) && hdr_last_reg;
                    phase_next             = 1'b0;
                    emit_next              = emit_reg + 6'd1;
                    if (emit_reg == icmp_pkg::IdxLast)
                    begin
                        state_next = hdr_last_reg ? StCollect : StPass;
                    end
                end
            end
            StPass:
            begin
                if (in_xfer)
                begin
                    out_valid_next         = 1'b1;
                    out_item_next.out_byte = in_item.in_byte;
                    out_item_next.out_last = in_item.in_last;
                    if (in_item.in_last)
                    begin
                        state_next = StCollect;
                    end
                end
            end
            StDrop:
            begin
                if (in_xfer && in_item.in_last)
                begin
                    state_next = StCollect;
                end
            end
            default:
            begin
                state_next = StCollect;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StCollect;
            cnt_reg       <= '0;
            emit_reg      <= '0;
            phase_reg     <= 1'b0;
            hdr_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            emit_reg      <= emit_next;
            phase_reg     <= phase_next;
            hdr_last_reg  <= hdr_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

// ----- sim/icmp_echo_responder_core_tb.sv -----
// self-checking testbench of the icmp echo responder core
`default_nettype none
module icmp_echo_responder_core_tb;

    localparam logic [icmp_pkg::AddrWidth-1:0] AddrLocalMac = {icmp_pkg::RegLocalMac, 3'b000};
    localparam logic [icmp_pkg::AddrWidth-1:0] AddrLocalIp  = {icmp_pkg::RegLocalIp, 3'b000};
    localparam int IdlePct     = 27;
    localparam int HoldCycles  = 400;
    localparam int DrainCycles = 120;
    localparam int LimitCycles = 400000;

    typedef enum logic [1:0] {
        ModeCollect,
        ModePass,
        ModeDrop
    } frame_mode_t;

    typedef enum int {
        FrameEcho,
        FrameBadMac,
        FrameBadEthHi,
        FrameBadEthLo,
        FrameBadProto,
        FrameBadIp,
        FrameBadType,
        FrameNoise
    } frame_kind_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    icmp_pkg::in_item_t             in_item = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    icmp_pkg::out_item_t            out_item;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [icmp_pkg::AddrWidth-1:0] paddr = '0;
    logic [icmp_pkg::DataWidth-1:0] pwdata = '0;
    logic [icmp_pkg::DataWidth-1:0] prdata;
    logic                           pready;

    icmp_pkg::in_item_t  byte_q[$];
    icmp_pkg::out_item_t reply_q[$];
    logic [47:0]         cfg_mac = '0;
    logic [31:0]         cfg_ip = '0;
    logic [7:0]          hdr_buf [icmp_pkg::HdrLen];
    int                  hdr_cnt = 0;
    frame_mode_t         mode = ModeCollect;
    int                  err_cnt = 0;
    int                  src_idle_pct = IdlePct;
    int                  sink_idle_pct = IdlePct;
    int                  hold_gen = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;
    int                  cycle_cnt = 0;

    icmp_echo_responder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic logic [15:0] ones_fold(input logic [31:0] s);
        logic [31:0] t;
        t = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
        return t[15:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    task automatic predict_reply(input icmp_pkg::in_item_t it);
        logic [7:0]          rep [icmp_pkg::HdrLen];
        logic [47:0]         dmac;
        logic [31:0]         dip;
        logic [31:0]         sum;
        logic [15:0]         ck;
        logic                hit;
        icmp_pkg::out_item_t o;
        if (mode == ModePass)
        begin
            o.out_byte = it.in_byte;
            o.out_last = it.in_last;
            reply_q.push_back(o);
            if (it.in_last)
            begin
                mode = ModeCollect;
            end
        end
        else if (mode == ModeDrop)
        begin
            if (it.in_last)
            begin
                mode = ModeCollect;
                hdr_cnt = 0;
            end
        end
        else
        begin
            hdr_buf[hdr_cnt] = it.in_byte;
            hdr_cnt++;
            if (hdr_cnt < icmp_pkg::HdrLen)
            begin
                if (it.in_last)
                begin
                    hdr_cnt = 0;
                end
            end
            else
            begin
                hdr_cnt = 0;
                dmac = {hdr_buf[0], hdr_buf[1], hdr_buf[2], hdr_buf[3], hdr_buf[4], hdr_buf[5]};
                dip = {hdr_buf[30], hdr_buf[31], hdr_buf[32], hdr_buf[33]};
                hit = hdr_buf[12] == icmp_pkg::EthTypeIpv4Hi
                    && hdr_buf[13] == icmp_pkg::EthTypeIpv4Lo
                    && dmac == cfg_mac && hdr_buf[23] == icmp_pkg::ProtoIcmp
                    && dip == cfg_ip && hdr_buf[34] == icmp_pkg::IcmpEchoReq;
                if (!hit)
                begin
                    mode = it.in_last ? ModeCollect : ModeDrop;
                end
                else
                begin
                    rep = hdr_buf;
                    for (int i = 0; i < 6; i++)
                    begin
                        rep[i] = hdr_buf[6 + i];
                        rep[6 + i] = hdr_buf[i];
                    end
                    for (int i = 0; i < 4; i++)
                    begin
                        rep[26 + i] = hdr_buf[30 + i];
                        rep[30 + i] = hdr_buf[26 + i];
                    end
                    rep[24] = 8'h00;
                    rep[25] = 8'h00;
                    sum = '0;
                    for (int i = 14; i < 34; i += 2)
                    begin
                        sum += {16'h0, rep[i], rep[i + 1]};
                    end
                    ck = ~ones_fold(sum);
                    rep[24] = ck[15:8];
                    rep[25] = ck[7:0];
                    rep[34] = icmp_pkg::IcmpEchoReply;
                    ck = {hdr_buf[36], hdr_buf[37]};
                    sum = {16'h0, ~ck} + {16'h0, icmp_pkg::IcmpCkAdjust};
                    ck = ~ones_fold(sum);
                    rep[36] = ck[15:8];
                    rep[37] = ck[7:0];
                    for (int i = 0; i < icmp_pkg::HdrLen; i++)
                    begin
                        o.out_byte = rep[i];
                        o.out_last = (i == icmp_pkg::HdrLen - 1) && it.in_last;
                        reply_q.push_back(o);
                    end
                    mode = it.in_last ? ModeCollect : ModePass;
                end
            end
        end
    endtask

    // fill < 0 gives random filler bytes
    task automatic queue_frame(input frame_kind_t kind, input int len, input int fill);
        logic [7:0]         hdr [icmp_pkg::HdrLen];
        icmp_pkg::in_item_t it;
        logic [7:0]         flip;
        for (int i = 0; i < icmp_pkg::HdrLen; i++)
        begin
            hdr[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
        end
        if (kind != FrameNoise)
        begin
            for (int i = 0; i < 6; i++)
            begin
                hdr[i] = cfg_mac[47 - 8*i -: 8];
            end
            for (int i = 0; i < 4; i++)
            begin
                hdr[30 + i] = cfg_ip[31 - 8*i -: 8];
            end
            hdr[12] = icmp_pkg::EthTypeIpv4Hi;
            hdr[13] = icmp_pkg::EthTypeIpv4Lo;
            hdr[23] = icmp_pkg::ProtoIcmp;
            hdr[34] = icmp_pkg::IcmpEchoReq;
        end
        flip = 8'(1 << $urandom_range(7));
        case (kind)
            FrameBadMac:   hdr[$urandom_range(5)] ^= flip;
            FrameBadEthHi: hdr[12] ^= flip;
            FrameBadEthLo: hdr[13] ^= flip;
            FrameBadProto: hdr[23] ^= flip;
            FrameBadIp:    hdr[30 + $urandom_range(3)] ^= flip;
            FrameBadType:  hdr[34] ^= flip;
            default:       ;
        endcase
        for (int i = 0; i < len; i++)
        begin
            if (i < icmp_pkg::HdrLen)
            begin
                it.in_byte = hdr[i];
            end
            else
            begin
                it.in_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
            end
            it.in_last = (i == len - 1);
            byte_q.push_back(it);
        end
    endtask

    task automatic write_reg(input logic [icmp_pkg::AddrWidth-1:0] addr,
                             input logic [icmp_pkg::DataWidth-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == AddrLocalMac)
        begin
            cfg_mac = data[47:0];
        end
        else if (addr == AddrLocalIp)
        begin
            cfg_ip = data[31:0];
        end
    endtask

    task automatic drain();
        while (byte_q.size() != 0 || in_valid || reply_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainCycles) @(negedge clk);
    endtask

    // input side: one transfer per accepted byte
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_reply(in_item);
            end
            if (!in_valid || in_ready)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_item <= byte_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (reply_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transfer byte %02h last %0b",
                                              out_item.out_byte, out_item.out_last));
                end
                else
                begin
                    if (out_item.out_byte !== reply_q[0].out_byte)
                    begin
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                                  out_item.out_byte, reply_q[0].out_byte));
                    end
                    if (out_item.out_last !== reply_q[0].out_last)
                    begin
                        report_mismatch($sformatf("out_last got %0b want %0b",
                                                  out_item.out_last, reply_q[0].out_last));
                    end
                    void'(reply_q.pop_front());
                end
            end
            if (hold_seen != hold_gen)
            begin
                hold_seen <= hold_gen;
                hold_left <= HoldCycles;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LimitCycles)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(AddrLocalMac, {$urandom, $urandom});
        write_reg(AddrLocalIp, {$urandom, $urandom});
        @(negedge clk);
        queue_frame(frame_kind_t'($urandom_range(FrameBadMac, FrameBadType)),
                    icmp_pkg::HdrLen + 2, -1);
        queue_frame(FrameNoise, 1, -1);
        drain();

        // no idling on either side
        write_reg(AddrLocalMac, '1);
        write_reg(AddrLocalIp, '1);
        @(negedge clk);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        queue_frame(FrameEcho, icmp_pkg::HdrLen, 8'hff);
        drain();
        src_idle_pct = IdlePct;
        sink_idle_pct = IdlePct;

        // receiver holds off while the sender keeps offering
        write_reg(AddrLocalMac, {$urandom, $urandom});
        write_reg(AddrLocalIp, {$urandom, $urandom});
        @(negedge clk);
        queue_frame(FrameEcho, icmp_pkg::HdrLen + 2, -1);
        hold_gen++;
        drain();

        if (err_cnt == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
